// ===== hdl/spq_pkg.sv =====
package spq_pkg;

    localparam int IdWidth   = 16;
    localparam int PrioWidth = 4;
    localparam int ReqWidth  = 8;
    localparam int CntWidth  = 6;

    localparam logic [PrioWidth-1:0] PrioMin = 4'd1;
    localparam logic [PrioWidth-1:0] PrioMax = 4'd9;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic                       kind;
        logic [IdWidth-1:0]         case_id;
        logic signed [ReqWidth-1:0] priority_req;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           status;
        logic [IdWidth-1:0]   removed_id;
        logic [PrioWidth-1:0] removed_priority;
        logic [CntWidth-1:0]  entry_count;
    } t_out_item;

    typedef struct packed {
        logic [IdWidth-1:0]   id;
        logic [PrioWidth-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic   ins;
        logic   pop;
        t_entry ent;
    } t_cell_ctl;

    function automatic logic [PrioWidth-1:0] clamp_prio(logic signed [ReqWidth-1:0] req);
        logic [PrioWidth-1:0] res;
        if (req < $signed({1'b0, PrioMin})) begin
            res = PrioMin;
        end else if (req > $signed({1'b0, PrioMax})) begin
            res = PrioMax;
        end else begin
            res = req[PrioWidth-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/stable_priority_queue.sv =====
// A result is computed when its item is accepted and is registered in the result buffer.
// Throughput: one item per cycle while o_ready is high; the chain updates in that same cycle.
// A two-item result buffer lets input items keep entering while a result waits.
// Reset (synchronous, active low) empties the queue and the result buffer at once;
// stored entries are not cleared, only the entry count is.
module stable_priority_queue #(
    parameter int CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  spq_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output spq_pkg::t_out_item o_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    spq_pkg::t_cell_ctl w_ctl;
    spq_pkg::t_out_item w_res;
    logic [CW+5:0]      w_cnt_ext;
    logic               w_take  [CAPACITY];
    spq_pkg::t_entry    w_entry [CAPACITY];

    assign w_accept = i_valid && o_ready;
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_empty  = (r_count == '0);

    always_comb begin
        w_ctl.ins     = w_accept && (i_data.kind == spq_pkg::KIND_INSERT) && !w_full;
        w_ctl.pop     = w_accept && (i_data.kind == spq_pkg::KIND_REMOVE) && !w_empty;
        w_ctl.ent.id  = i_data.case_id;
        w_ctl.ent.prio = spq_pkg::clamp_prio(i_data.priority_req);
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_ctl.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    assign w_cnt_ext = {6'b0, n_count};

    always_comb begin
        w_res.status           = spq_pkg::ST_DONE;
        w_res.removed_id       = '0;
        w_res.removed_priority = '0;
        w_res.entry_count      = w_cnt_ext[5:0];
        if (i_data.kind == spq_pkg::KIND_INSERT) begin
            if (w_full) begin
                w_res.status = spq_pkg::ST_FULL;
            end
        end else if (w_empty) begin
            w_res.status = spq_pkg::ST_EMPTY;
        end else begin
            w_res.removed_id       = w_entry[0].id;
            w_res.removed_priority = w_entry[0].prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic            w_prev_take;
        spq_pkg::t_entry w_left;
        spq_pkg::t_entry w_right;

        if (g == 0) begin : g_first
            assign w_prev_take = 1'b0;
            assign w_left      = w_ctl.ent;
        end else begin : g_mid
            assign w_prev_take = w_take[g-1];
            assign w_left      = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occupied  (CW'(g) < r_count),
            .i_take_prev (w_prev_take),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_take      (w_take[g]),
            .o_entry     (w_entry[g])
        );
    end

    spq_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_item  (w_res),
        .o_space (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_data)
    );

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_data.kind == spq_pkg::KIND_INSERT) && !w_full
        |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the queue");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_data.kind == spq_pkg::KIND_REMOVE) && w_empty |=> r_count == '0)
        else $error("removal from empty queue changed count");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CW'(2) |-> w_entry[0].prio <= w_entry[1].prio)
        else $error("head entries out of order");
`endif

endmodule

// ===== hdl/spq_cell.sv =====
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  logic               i_take_prev,
    input  spq_pkg::t_entry    i_left,
    input  spq_pkg::t_entry    i_right,
    output logic               o_take,
    output spq_pkg::t_entry    o_entry
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // monotonic along the chain: the new item lands where take first goes high
    assign o_take  = !i_occupied || (i_ctl.ent.prio < r_entry.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (i_take_prev) begin
                n_entry = i_left;
            end else if (o_take) begin
                n_entry = i_ctl.ent;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== hdl/spq_out_buf.sv =====
module spq_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  spq_pkg::t_out_item i_item,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_ready,
    output spq_pkg::t_out_item o_item
);

    spq_pkg::t_out_item r_slot0;
    spq_pkg::t_out_item r_slot1;
    logic               r_v0;
    logic               r_v1;
    spq_pkg::t_out_item n_slot0;
    spq_pkg::t_out_item n_slot1;
    logic               n_v0;
    logic               n_v1;
    logic               w_pop;

    assign o_space = !r_v1;
    assign o_valid = r_v0;
    assign o_item  = r_slot0;
    assign w_pop   = r_v0 && i_ready;

    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_v0    = r_v0;
        n_v1    = r_v1;
        if (w_pop) begin
            if (r_v1) begin
                n_slot0 = r_slot1;
                n_v0    = 1'b1;
                n_v1    = i_push;
                n_slot1 = i_item;
            end else begin
                n_v0    = i_push;
                n_slot0 = i_item;
            end
        end else if (i_push) begin
            if (!r_v0) begin
                n_slot0 = i_item;
                n_v0    = 1'b1;
            end else begin
                n_slot1 = i_item;
                n_v1    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule

// ===== verif/stable_priority_queue_tb.sv =====
`timescale 1ns / 100ps

module stable_priority_queue_tb;

    localparam int QueueDepth = 32;
    localparam int HangLimit  = 2000;
    localparam int RandItems  = 2000;
    localparam int FieldW     = spq_pkg::IdWidth;
    localparam int ReqW       = spq_pkg::ReqWidth;
    localparam int CntW       = spq_pkg::CntWidth;

    typedef struct {
        spq_pkg::t_in_item item;
        int                gap;
    } t_pending;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_ready = 1'b0;
    spq_pkg::t_in_item  i_data  = '0;
    logic               o_ready;
    logic               o_valid;
    spq_pkg::t_out_item o_data;

    t_pending           pending[$];
    spq_pkg::t_out_item expected[$];
    spq_pkg::t_entry    held[$];

    logic      in_taken = 1'b0;
    int        gap_left = 0;
    int        stall_left = 0;
    int        sink_phase_left = 0;
    bit        sink_calm = 1'b0;
    int        err_cnt = 0;
    int        n_placed = 0;
    int        n_removed = 0;
    int        n_full = 0;
    int        n_empty = 0;

    stable_priority_queue #(
        .CAPACITY(QueueDepth)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // mostly back-to-back, some short pauses, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // queue model: sorted by level, new entry goes after all equal or more urgent ones
    function automatic spq_pkg::t_out_item serve_item(spq_pkg::t_in_item it);
        spq_pkg::t_out_item r;
        spq_pkg::t_entry    e;
        int                 lvl;
        int                 pos;
        r = '0;
        if (it.kind == spq_pkg::KIND_INSERT) begin
            lvl = $signed(it.priority_req);
            if (lvl < int'(spq_pkg::PrioMin)) lvl = int'(spq_pkg::PrioMin);
            if (lvl > int'(spq_pkg::PrioMax)) lvl = int'(spq_pkg::PrioMax);
            if (held.size() >= QueueDepth) begin
                r.status = spq_pkg::ST_FULL;
            end else begin
                e.id   = it.case_id;
                e.prio = lvl[spq_pkg::PrioWidth-1:0];
                pos = held.size();
                for (int i = 0; i < held.size(); i++) begin
                    if (e.prio < held[i].prio) begin
                        pos = i;
                        break;
                    end
                end
                held.insert(pos, e);
                r.status = spq_pkg::ST_DONE;
            end
        end else begin
            if (held.size() == 0) begin
                r.status = spq_pkg::ST_EMPTY;
            end else begin
                e = held.pop_front();
                r.status           = spq_pkg::ST_DONE;
                r.removed_id       = e.id;
                r.removed_priority = e.prio;
            end
        end
        r.entry_count = CntW'(held.size());
        return r;
    endfunction

    task automatic add_item(spq_pkg::t_kind kind, logic [FieldW-1:0] id,
                            logic signed [ReqW-1:0] req, int gap);
        t_pending p;
        p.item.kind         = kind;
        p.item.case_id      = id;
        p.item.priority_req = req;
        p.gap               = gap;
        pending.push_back(p);
    endtask

    task automatic check_field(string name, logic [FieldW-1:0] want, logic [FieldW-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    always @(negedge i_clk) begin : driver
        t_pending nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending.size() > 0) begin
                nxt = pending.pop_front();
                gap_left = nxt.gap;
                i_data  <= nxt.item;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : sink
        if (sink_phase_left == 0) begin
            sink_calm = ($urandom_range(0, 2) == 0);
            sink_phase_left = $urandom_range(50, 300);
        end else begin
            sink_phase_left--;
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            stall_left = sink_calm ? 0 : pick_gap();
        end
    end

    always @(posedge i_clk) begin : monitor
        spq_pkg::t_out_item want;
        in_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected.size() == 0) begin
                $error("result with nothing expected: %h", o_data);
                err_cnt++;
            end else begin
                want = expected.pop_front();
                check_field("status", FieldW'(want.status), FieldW'(o_data.status));
                check_field("removed_id", want.removed_id, o_data.removed_id);
                check_field("removed_priority", FieldW'(want.removed_priority),
                            FieldW'(o_data.removed_priority));
                check_field("entry_count", FieldW'(want.entry_count),
                            FieldW'(o_data.entry_count));
                case (want.status)
                    spq_pkg::ST_FULL:  n_full++;
                    spq_pkg::ST_EMPTY: n_empty++;
                    default: begin
                        if (want.removed_priority != '0) n_removed++;
                        else n_placed++;
                    end
                endcase
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            expected.push_back(serve_item(i_data));
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < HangLimit) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle = 0;
            else idle++;
        end
        $display("stable_priority_queue: mismatch");
        $finish;
    end

    initial begin : stimulus
        int                     total;
        int                     run_len;
        int                     ins_pct;
        bit                     calm;
        spq_pkg::t_kind         kind;
        logic signed [ReqW-1:0] req;

        // empty pop, clamping at both ends, ties, then drain past empty
        add_item(spq_pkg::KIND_REMOVE, 16'hFFFF, -8'sd1, pick_gap());
        add_item(spq_pkg::KIND_INSERT, 16'h0000, -8'sd128, pick_gap());
        add_item(spq_pkg::KIND_INSERT, 16'hFFFF, 8'sd127, pick_gap());
        add_item(spq_pkg::KIND_INSERT, 16'h1234, 8'sd0, pick_gap());
        add_item(spq_pkg::KIND_INSERT, 16'h5678, 8'sd10, pick_gap());
        add_item(spq_pkg::KIND_INSERT, 16'hA5A5, 8'sd5, pick_gap());
        add_item(spq_pkg::KIND_INSERT, 16'h5A5A, 8'sd1, pick_gap());
        add_item(spq_pkg::KIND_INSERT, 16'h0F0F, 8'sd9, pick_gap());
        add_item(spq_pkg::KIND_INSERT, 16'hF0F0, -8'sd1, pick_gap());
        for (int i = 0; i < 9; i++) begin
            add_item(spq_pkg::KIND_REMOVE, 16'(i * 16'h1111), 8'(i * 37 - 128), pick_gap());
        end

        // phases leaning toward fill, drain or a mix, so full and empty both recur
        total = 0;
        while (total < RandItems) begin
            run_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0:       ins_pct = 90;
                1:       ins_pct = 15;
                default: ins_pct = 50;
            endcase
            calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < run_len; i++) begin
                kind = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::KIND_INSERT
                                                         : spq_pkg::KIND_REMOVE;
                if ($urandom_range(0, 4) != 0) req = ReqW'($urandom_range(0, 13) - 2);
                else req = ReqW'($urandom());
                add_item(kind, FieldW'($urandom()), req, calm ? 0 : pick_gap());
            end
            total += run_len;
        end

        @(posedge i_clk);
        while (!i_rst_n || pending.size() != 0 || i_valid) @(posedge i_clk);
        while (expected.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        $display("checked %0d results: %0d placed, %0d removed,",
                 n_placed + n_removed + n_full + n_empty, n_placed, n_removed);
        $display("%0d inserts refused full, %0d removals refused empty", n_full, n_empty);
        if (err_cnt == 0) begin
            $display("stable_priority_queue: match");
        end else begin
            $display("stable_priority_queue: mismatch");
        end
        $finish;
    end

endmodule
